// ----- rtl/rbst_pkg.sv -----
// Package for the ray versus box slab test block.
// Holds the shared widths, pipeline depths, register indexes and the lane result type.
// No dependencies.
package rbst_pkg;

    localparam int NUM_AXES    = 3;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int DIV_STAGES  = COORD_W;
    localparam int DIV_LAT     = DIV_STAGES + 1;
    localparam int AXIS_LAT    = DIV_LAT + 2;
    localparam int MERGE_LAT   = 3;
    localparam int PIPE_DEPTH  = AXIS_LAT + MERGE_LAT;

    localparam int S_TDATA_W   = 4 * NUM_AXES * COORD_W;
    localparam int M_TDATA_W   = 8;

    localparam int MAXD_W      = 31;
    localparam int EPS_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = MAXD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_EPSILON = 1'b1;

    localparam logic [MAXD_W-1:0] MAXD_RESET = 31'h7FFF_FFFF;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 17'd1;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord T_MAX = 32'sh7FFF_FFFF;
    localparam t_coord T_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic   par;
        logic   slab_miss;
        t_coord t_lo;
        t_coord t_hi;
    } t_axis_res;

endpackage

// ----- rtl/rbst_div.sv -----
// Pipelined restoring divider for one slab distance, one quotient bit per stage.
// Divides a corner difference scaled by 2^16 by a direction magnitude and saturates.
// Depends on rbst_pkg.
module rbst_div import rbst_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [COORD_W:0]   i_num,
    input  logic [COORD_W-1:0] i_den,
    input  logic               i_neg,
    output t_coord             o_t
);

    logic [COORD_W-1:0] r_rem [1:DIV_STAGES-1];
    logic [COORD_W-1:0] r_nq  [1:DIV_STAGES];
    logic [COORD_W-1:0] r_den [1:DIV_STAGES-1];
    logic               r_neg [1:DIV_STAGES];
    logic               r_ovf [1:DIV_STAGES];

    logic [COORD_W-1:0] w_rem0;
    logic [COORD_W-1:0] w_nq0;
    logic               w_ovf0;
    logic [COORD_W-1:0] w_q;

    assign w_rem0 = COORD_W'(i_num[COORD_W:FRAC_W]);
    assign w_nq0  = {i_num[FRAC_W-1:0], {(COORD_W-FRAC_W){1'b0}}};
    assign w_ovf0 = w_rem0 >= i_den;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [COORD_W-1:0] a_rem;
        logic [COORD_W-1:0] a_nq;
        logic [COORD_W-1:0] a_den;
        logic               a_neg;
        logic               a_ovf;
        logic [COORD_W:0]   a_part;
        logic [COORD_W+1:0] a_trial;
        logic               a_ge;

        if (s == 0) begin : g_first
            assign a_rem = w_rem0;
            assign a_nq  = w_nq0;
            assign a_den = i_den;
            assign a_neg = i_neg;
            assign a_ovf = w_ovf0;
        end else begin : g_next
            assign a_rem = r_rem[s];
            assign a_nq  = r_nq[s];
            assign a_den = r_den[s];
            assign a_neg = r_neg[s];
            assign a_ovf = r_ovf[s];
        end

        assign a_part  = {a_rem, a_nq[COORD_W-1]};
        assign a_trial = {1'b0, a_part} - {2'b00, a_den};
        assign a_ge    = !a_trial[COORD_W+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s+1]  <= {a_nq[COORD_W-2:0], a_ge};
                r_neg[s+1] <= a_neg;
                r_ovf[s+1] <= a_ovf;
            end
        end

        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= a_ge ? a_trial[COORD_W-1:0] : a_part[COORD_W-1:0];
                    r_den[s+1] <= a_den;
                end
            end
        end
    end

    assign w_q = r_nq[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_STAGES]) begin
                if (r_ovf[DIV_STAGES] || (w_q[COORD_W-1] && (w_q[COORD_W-2:0] != '0))) begin
                    o_t <= T_MIN;
                end else begin
                    o_t <= -w_q;
                end
            end else begin
                if (r_ovf[DIV_STAGES] || w_q[COORD_W-1]) begin
                    o_t <= T_MAX;
                end else begin
                    o_t <= w_q;
                end
            end
        end
    end

endmodule

// ----- rtl/rbst_axis.sv -----
// One axis lane: slab differences, parallel check, two dividers and entry/exit ordering.
// Depends on rbst_pkg and rbst_div.
module rbst_axis import rbst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_coord           i_lo,
    input  t_coord           i_hi,
    input  t_coord           i_org,
    input  t_coord           i_dir,
    input  logic [EPS_W-1:0] i_eps,
    output t_axis_res        o_res
);

    logic signed [COORD_W:0] w_diff_lo;
    logic signed [COORD_W:0] w_diff_hi;
    logic [COORD_W:0]        w_lo_mag;
    logic [COORD_W:0]        w_hi_mag;
    logic [COORD_W-1:0]      w_dir_mag;
    logic                    w_par;
    logic                    w_outside;

    logic [COORD_W:0]        r_lo_mag;
    logic [COORD_W:0]        r_hi_mag;
    logic [COORD_W-1:0]      r_dir_mag;
    logic                    r_lo_neg;
    logic                    r_hi_neg;
    logic                    r_par;
    logic                    r_slab_miss;
    logic [1:0]              r_flag_dly [DIV_LAT];

    t_coord                  w_t1;
    t_coord                  w_t2;

    assign w_diff_lo = (COORD_W+1)'(i_lo) - (COORD_W+1)'(i_org);
    assign w_diff_hi = (COORD_W+1)'(i_hi) - (COORD_W+1)'(i_org);
    assign w_lo_mag  = w_diff_lo[COORD_W] ? (COORD_W+1)'(-w_diff_lo) : w_diff_lo;
    assign w_hi_mag  = w_diff_hi[COORD_W] ? (COORD_W+1)'(-w_diff_hi) : w_diff_hi;
    assign w_dir_mag = i_dir[COORD_W-1] ? COORD_W'(-i_dir) : i_dir;
    assign w_par     = (i_dir == '0) || (w_dir_mag < COORD_W'(i_eps));
    assign w_outside = (i_org < i_lo) || (i_org > i_hi);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_mag    <= w_lo_mag;
            r_hi_mag    <= w_hi_mag;
            r_dir_mag   <= w_dir_mag;
            r_lo_neg    <= w_diff_lo[COORD_W] ^ i_dir[COORD_W-1];
            r_hi_neg    <= w_diff_hi[COORD_W] ^ i_dir[COORD_W-1];
            r_par       <= w_par;
            r_slab_miss <= w_par && w_outside;
        end
    end

    rbst_div u_div_lo (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_lo_mag),
        .i_den (r_dir_mag),
        .i_neg (r_lo_neg),
        .o_t   (w_t1)
    );

    rbst_div u_div_hi (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_hi_mag),
        .i_den (r_dir_mag),
        .i_neg (r_hi_neg),
        .o_t   (w_t2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flag_dly[0] <= {r_par, r_slab_miss};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_flag_dly[k] <= r_flag_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.par       <= r_flag_dly[DIV_LAT-1][1];
            o_res.slab_miss <= r_flag_dly[DIV_LAT-1][0];
            o_res.t_lo      <= (w_t1 > w_t2) ? w_t2 : w_t1;
            o_res.t_hi      <= (w_t1 > w_t2) ? w_t1 : w_t2;
        end
    end

endmodule

// ----- rtl/rbst_merge.sv -----
// Merge stage: intersects the three axis intervals with the segment range and decides the hit.
// Depends on rbst_pkg.
module rbst_merge import rbst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  t_axis_res         i_axis [NUM_AXES],
    input  logic [MAXD_W-1:0] i_max_distance,
    output logic              o_hit
);

    function automatic t_coord f_max(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord f_min(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    t_coord w_lo [NUM_AXES];
    t_coord w_hi [NUM_AXES];
    t_coord w_maxd;
    logic   w_miss;

    t_coord r1_lo_a;
    t_coord r1_lo_b;
    t_coord r1_hi_a;
    t_coord r1_hi_b;
    logic   r1_miss;
    t_coord r2_tmin;
    t_coord r2_tmax;
    logic   r2_miss;

    assign w_maxd = t_coord'({1'b0, i_max_distance});

    always_comb begin
        w_miss = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            w_lo[k] = i_axis[k].par ? '0 : i_axis[k].t_lo;
            w_hi[k] = i_axis[k].par ? T_MAX : i_axis[k].t_hi;
            w_miss  = w_miss | i_axis[k].slab_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lo_a <= f_max('0, w_lo[0]);
            r1_lo_b <= f_max(w_lo[1], w_lo[2]);
            r1_hi_a <= f_min(w_maxd, w_hi[0]);
            r1_hi_b <= f_min(w_hi[1], w_hi[2]);
            r1_miss <= w_miss;
            r2_tmin <= f_max(r1_lo_a, r1_lo_b);
            r2_tmax <= f_min(r1_hi_a, r1_hi_b);
            r2_miss <= r1_miss;
            o_hit   <= !r2_miss && (r2_tmin <= r2_tmax);
        end
    end

endmodule

// ----- rtl/ray_box_slab_test_top.sv -----
// Top level of the ray versus box slab test: stream ports, configuration registers,
// three axis lanes, the merge stage and the output skid buffer.
// Depends on rbst_pkg, rbst_axis and rbst_merge.
// Throughput: one word per cycle while the skid entry is empty; the three axis lanes each run two 32-stage dividers.
// The output register plus one skid entry let the pipeline advance while a result waits.
// Reset (synchronous, active low) empties the pipeline and restores both registers.
module ray_box_slab_test_top import rbst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z; 32 bits each.
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit in bit 0, zeros above.
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic [MAXD_W-1:0] r_max_distance;
    logic [EPS_W-1:0]  r_eps;
    logic              r_valid [1:PIPE_DEPTH];
    logic              r_out_valid;
    logic              r_out_hit;
    logic              r_skid_valid;
    logic              r_skid_hit;
    logic              w_pipe_en;
    logic              w_pipe_hit;
    t_axis_res         w_axis_res [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance <= MAXD_RESET;
            r_eps          <= EPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_DISTANCE:     r_max_distance <= i_cfg_wdata[MAXD_W-1:0];
                CFG_PARALLEL_EPSILON: r_eps          <= i_cfg_wdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_pipe_en     = !r_skid_valid;
    assign s_axis_tready = w_pipe_en;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rbst_axis u_axis (
            .i_clk (i_clk),
            .i_en  (w_pipe_en),
            .i_lo  (s_axis_tdata[COORD_W*a +: COORD_W]),
            .i_hi  (s_axis_tdata[COORD_W*(NUM_AXES+a) +: COORD_W]),
            .i_org (s_axis_tdata[COORD_W*(2*NUM_AXES+a) +: COORD_W]),
            .i_dir (s_axis_tdata[COORD_W*(3*NUM_AXES+a) +: COORD_W]),
            .i_eps (r_eps),
            .o_res (w_axis_res[a])
        );
    end

    rbst_merge u_merge (
        .i_clk          (i_clk),
        .i_en           (w_pipe_en),
        .i_axis         (w_axis_res),
        .i_max_distance (r_max_distance),
        .o_hit          (w_pipe_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (w_pipe_en) begin
            r_valid[1] <= s_axis_tvalid;
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_valid[PIPE_DEPTH];
            end
        end else if (r_valid[PIPE_DEPTH] && w_pipe_en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out_hit <= r_skid_valid ? r_skid_hit : w_pipe_hit;
        end else if (r_valid[PIPE_DEPTH] && w_pipe_en) begin
            r_skid_hit <= w_pipe_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_hit);

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a word while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && m_axis_tready |=> !r_skid_valid)
        else $error("skid entry did not drain after the output word was taken");

    a_held_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && !r_skid_valid && r_valid[PIPE_DEPTH]
        |=> r_skid_valid)
        else $error("finished word was not captured while the output was stalled");

endmodule

// ----- dv/ray_box_slab_test_top_checker.sv -----
// Checker for the ray versus box slab test: watches the configuration port and both stream
// channels, predicts the hit bit of every accepted word and compares it with the output.
// Depends on rbst_pkg.
module ray_box_slab_test_top_checker import rbst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MAXD_W-1:0] seg_length;
    logic [EPS_W-1:0]  par_eps;
    logic              expected_hits[$];
    logic              want_hit;

    function automatic t_coord coord(input logic [S_TDATA_W-1:0] word, input int idx);
        return word[idx*COORD_W +: COORD_W];
    endfunction

    function automatic longint slab_time(input longint corner, input longint org,
                                         input longint dir);
        longint q;
        q = ((corner - org) * 64'sd65536) / dir;
        if (q > longint'(T_MAX))
            q = T_MAX;
        if (q < longint'(T_MIN))
            q = T_MIN;
        return q;
    endfunction

    function automatic logic slab_hit(input logic [S_TDATA_W-1:0] word,
                                      input logic [MAXD_W-1:0] len,
                                      input logic [EPS_W-1:0] eps);
        longint t_near, t_far, lo, hi, org, dir, mag, eps_l, t1, t2, t_in, t_out;
        logic   hit;
        t_near = 0;
        t_far  = len;
        eps_l  = eps;
        hit    = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (hit) begin
                lo  = coord(word, a);
                hi  = coord(word, NUM_AXES + a);
                org = coord(word, 2 * NUM_AXES + a);
                dir = coord(word, 3 * NUM_AXES + a);
                mag = (dir < 0) ? -dir : dir;
                if (dir == 0 || mag < eps_l) begin
                    if (org < lo || org > hi)
                        hit = 1'b0;
                end else begin
                    t1    = slab_time(lo, org, dir);
                    t2    = slab_time(hi, org, dir);
                    t_in  = (t1 < t2) ? t1 : t2;
                    t_out = (t1 < t2) ? t2 : t1;
                    if (t_in > t_near)
                        t_near = t_in;
                    if (t_out < t_far)
                        t_far = t_out;
                    if (t_near > t_far)
                        hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_length   = MAXD_RESET;
            par_eps      = EPS_RESET;
            o_fail_count = 0;
            expected_hits.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_hits.size() == 0) begin
                    o_fail_count++;
                    $error("hit: expected no word, actual %0d", i_m_tdata[0]);
                end else begin
                    want_hit = expected_hits.pop_front();
                    if (i_m_tdata[0] !== want_hit) begin
                        o_fail_count++;
                        $error("hit: expected %0d, actual %0d", want_hit, i_m_tdata[0]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_hits.push_back(slab_hit(i_s_tdata, seg_length, par_eps));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_DISTANCE:     seg_length = i_cfg_wdata[MAXD_W-1:0];
                    CFG_PARALLEL_EPSILON: par_eps    = i_cfg_wdata[EPS_W-1:0];
                endcase
            end
        end
        o_pending = expected_hits.size();
    end

endmodule

// ----- dv/ray_box_slab_test_top_test.sv -----
// Top of the ray versus box slab test bench: clock, reset, register setup and ray words.
// The verdict comes from the failure and pending counts of ray_box_slab_test_top_checker.
// Depends on rbst_pkg, ray_box_slab_test_top and ray_box_slab_test_top_checker.
module ray_box_slab_test_top_test import rbst_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_coord U           = 32'sh0001_0000;
    localparam int     CYCLE_LIMIT = 200000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_MAX_DISTANCE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    logic quiet       = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    ray_box_slab_test_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ray_box_slab_test_top_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ray_box_slab_test_top: mismatch");
            $finish;
        end
    end

    task automatic set_config(input logic [MAXD_W-1:0] len, input logic [EPS_W-1:0] eps);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_DISTANCE;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_index <= CFG_PARALLEL_EPSILON;
        i_cfg_wdata <= CFG_DATA_W'(eps);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic send_ray(input t_coord lx, input t_coord ly, input t_coord lz,
                            input t_coord hx, input t_coord hy, input t_coord hz,
                            input t_coord ox, input t_coord oy, input t_coord oz,
                            input t_coord dx, input t_coord dy, input t_coord dz);
        if (!quiet && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dz, dy, dx, oz, oy, ox, hz, hy, hx, lz, ly, lx};
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    function automatic t_coord near_coord();
        return t_coord'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
    endfunction

    function automatic t_coord wild_coord();
        case ($urandom_range(0, 5))
            0:       return T_MIN;
            1:       return T_MAX;
            2:       return 0;
            3:       return 1;
            4:       return -1;
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_random_ray();
        t_coord lo[3], hi[3], org[3], dir[3];
        t_coord tgt, tmp;
        int     kind, shift;
        kind  = $urandom_range(0, 99);
        shift = $urandom_range(0, 99) < 30 ? $urandom_range(1, 3) : 0;
        for (int a = 0; a < 3; a++) begin
            if (kind < 65) begin
                lo[a]  = near_coord();
                hi[a]  = lo[a] + t_coord'($urandom_range(0, 32'h4_0000));
                tgt    = lo[a] + t_coord'($urandom_range(0, hi[a] - lo[a]));
                org[a] = near_coord();
                dir[a] = (tgt - org[a]) >>> shift;
                if ($urandom_range(0, 99) < 5) begin
                    tmp   = lo[a];
                    lo[a] = hi[a];
                    hi[a] = tmp;
                end
                case ($urandom_range(0, 9))
                    0:       dir[a] = 0;
                    1:       dir[a] = t_coord'($urandom_range(0, 4)) - 2;
                    default: ;
                endcase
            end else if (kind < 85) begin
                lo[a]  = t_coord'($urandom);
                hi[a]  = t_coord'($urandom);
                org[a] = t_coord'($urandom);
                dir[a] = t_coord'($urandom);
            end else begin
                lo[a]  = wild_coord();
                hi[a]  = wild_coord();
                org[a] = wild_coord();
                dir[a] = wild_coord();
            end
        end
        send_ray(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                 org[0], org[1], org[2], dir[0], dir[1], dir[2]);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(MAXD_RESET, 17'd1);
        send_ray(-U, -U, -U, U, U, U, -5*U, 0, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, -5*U, 2*U, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, -5*U, U, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, -5*U, 0, -U, U, 0, 0);
        send_ray(U, -U, -U, -U, U, U, -5*U, 0, 0, U, 0, 0);
        send_ray(-U, U, -U, U, -U, U, -5*U, 0, 0, U, 0, 0);
        send_ray(0, -U, -U, 0, U, U, -U, 0, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, 5*U, 0, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, 5*U, 0, 0, -U, 0, 0);
        send_ray(U, U, U, 2*U, 2*U, 2*U, 0, 0, 0, U, U, U);
        send_ray(U, U, U, 2*U, 2*U, 2*U, 0, 0, 0, U, 2*U, U);
        send_ray(U, U, U, 2*U, 2*U, 2*U, 0, 0, 0, U, 3*U, U);
        send_ray(T_MIN, -U, -U, T_MAX, U, U, 0, 0, 0, 1, 0, 0);
        send_ray(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX,
                 T_MIN, T_MIN, T_MIN);
        send_ray(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX,
                 T_MAX, T_MAX, T_MAX);
        send_ray(T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN,
                 T_MIN, T_MIN, T_MIN);
        send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_ray(U, -U, -U, 2*U, U, U, 0, 0, 0, 1, 0, 0);
        send_ray(U, -U, -U, 2*U, U, U, 0, 0, 0, -1, 0, 0);
        repeat (150) send_random_ray();
        wait_drained();

        set_config('0, '0);
        send_ray(-U, -U, -U, U, U, U, 0, 0, 0, 0, 0, 0);
        send_ray(-U, -U, -U, U, U, U, 0, 2*U, 0, 0, 0, 0);
        send_ray(0, -U, -U, U, U, U, 0, 0, 0, U, 0, 0);
        send_ray(U, -U, -U, 2*U, U, U, 0, 0, 0, U, 0, 0);
        send_ray(-U, -U, -U, U, U, U, 0, 0, 0, 1, 0, 0);
        repeat (60) send_random_ray();
        wait_drained();

        set_config(31'(10 * U), 17'd65536);
        send_ray(U, -U, -U, 2*U, U, U, 0, 0, 0, U, 0, 0);
        send_ray(U, -U, -U, 2*U, U, U, 0, 0, 0, U - 1, 0, 0);
        send_ray(-2*U, -U, -U, -U, U, U, 0, 0, 0, -U, 0, 0);
        send_ray(12*U, -U, -U, 13*U, U, U, 0, 0, 0, U, 0, 0);
        repeat (80) send_random_ray();
        wait_drained();

        quiet <= 1'b1;
        set_config(31'($urandom_range(0, 32'h7FFF_FFFF)), 17'($urandom_range(0, 65536)));
        repeat (110) send_random_ray();
        wait_drained();

        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ray_box_slab_test_top: match");
        end else begin
            $display("ray_box_slab_test_top: mismatch");
        end
        $finish;
    end

endmodule
